// File: hw/rtl/stfms_pkg.sv
`timescale 1ns / 1ps
package stfms_pkg;
  localparam int TableDepth = 1024;
  localparam int ValueWidth = 32;
  localparam int PosWidth = 11;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture item, init search bounds
    logic rd;          // issue table read at mid
    logic step;        // narrow bounds with read data
    logic shift_rd;    // read entry below shift pointer
    logic shift_wr;    // write read data one place up, step pointer down
    logic ins_wr;      // write key at insert point, count up
    logic chk_rd;      // read entry at lower bound
    logic finish;      // form result
    logic clear;       // empty the table
  } stfms_cmd_t;

  typedef struct packed {
    logic is_query;
    logic last;
    logic full;
    logic search_done; // lo == hi
    logic shift_done;  // shift pointer reached insert point
  } stfms_sts_t;
endpackage

// File: hw/rtl/stfms_datapath.sv
`timescale 1ns / 1ps
module stfms_datapath #(
  parameter int TABLE_DEPTH = stfms_pkg::TableDepth
) (
  input  logic clk,
  input  logic rst,
  input  stfms_pkg::stfms_cmd_t cmd,
  output stfms_pkg::stfms_sts_t sts,
  input  logic in_opcode,
  input  logic signed [stfms_pkg::ValueWidth-1:0] in_value,
  input  logic in_last,
  output logic [1:0] res_status,
  output logic [stfms_pkg::PosWidth-1:0] res_position
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [stfms_pkg::ValueWidth-1:0] mem [TABLE_DEPTH];
  logic signed [stfms_pkg::ValueWidth-1:0] rdata;
  logic signed [stfms_pkg::ValueWidth-1:0] key;
  logic op, last;
  logic [CW-1:0] count, lo, hi, ptr;
  logic [CW-1:0] mid;
  logic [AW-1:0] raddr;
  logic [CW-1:0] ptr_m1;
  logic less;

  assign mid = lo + ((hi - lo) >> 1);
  assign ptr_m1 = ptr - CW'(1);
  // insert uses upper bound (<=), query uses lower bound (<)
  assign less = op ? (rdata < key) : (rdata <= key);

  always_comb begin
    raddr = mid[AW-1:0];
    if (cmd.shift_rd) raddr = ptr_m1[AW-1:0];
    else if (cmd.chk_rd) raddr = lo[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.shift_rd || cmd.chk_rd) rdata <= mem[raddr];
    if (cmd.shift_wr) mem[ptr[AW-1:0]] <= rdata;
    else if (cmd.ins_wr) mem[lo[AW-1:0]] <= key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.ins_wr) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= in_value;
      op <= in_opcode;
      last <= in_last;
      lo <= '0;
      hi <= count;
    end else if (cmd.step) begin
      if (less) lo <= mid + CW'(1);
      else hi <= mid;
    end
    if (cmd.load) ptr <= count;
    else if (cmd.shift_wr) ptr <= ptr_m1;
    if (cmd.finish) begin
      res_position <= '0;
      if (!op) begin
        res_status <= stfms_pkg::ST_INSERTED;
      end else if (lo != count && rdata == key) begin
        res_status <= stfms_pkg::ST_FOUND;
        res_position <= stfms_pkg::PosWidth'(lo + CW'(1));
      end else begin
        res_status <= stfms_pkg::ST_NOT_FOUND;
      end
    end
  end

  assign sts.is_query = op;
  assign sts.last = last;
  assign sts.full = (count == CW'(TABLE_DEPTH));
  assign sts.search_done = (lo == hi);
  assign sts.shift_done = (ptr == lo);
endmodule

// File: hw/rtl/stfms_ctrl.sv
`timescale 1ns / 1ps
module stfms_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic full_drop,
  output stfms_pkg::stfms_cmd_t cmd,
  input  stfms_pkg::stfms_sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHKFULL = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_SHRD = 4'd4;
  localparam logic [3:0] S_SHWR = 4'd5;
  localparam logic [3:0] S_CHK = 4'd6;
  localparam logic [3:0] S_FIN = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state, state_next;
  logic full_flag, full_flag_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign full_drop = full_flag;

  always_comb begin
    cmd = '0;
    state_next = state;
    full_flag_next = full_flag;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHKFULL;
        end
      end
      S_CHKFULL: begin
        full_flag_next = !sts.is_query && sts.full;
        if (!sts.is_query && sts.full) state_next = S_OUT;
        else if (sts.search_done) state_next = sts.is_query ? S_CHK : S_SHRD;
        else begin
          cmd.rd = 1'b1;
          state_next = S_STEP;
        end
      end
      S_RD: begin
        if (sts.search_done) state_next = sts.is_query ? S_CHK : S_SHRD;
        else begin
          cmd.rd = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_next = S_RD;
      end
      S_SHRD: begin
        if (sts.shift_done) begin
          cmd.ins_wr = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next = S_SHRD;
      end
      S_CHK: begin
        cmd.chk_rd = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.is_query && sts.last) cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      full_flag <= 1'b0;
    end else begin
      state <= state_next;
      full_flag <= full_flag_next;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_clear_only_out: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> out_valid && out_ready)
    else $error("clear outside delivery");
endmodule

// File: hw/rtl/sorted_table_first_match_search_top.sv
`timescale 1ns / 1ps
// Sorted table of signed 32-bit values with first-match lookup.
// Input channel (valid/ready): opcode 0 inserts value after equal entries,
// opcode 1 queries it; last_query on a query empties the table once the
// answer is taken. Output channel (valid/ready): status and position,
// one result per item, in order.
// One item at a time. Insert: a binary search over the single table port,
// then each entry above the insert point is read and written one place up,
// then the key is written. Query: the same search, then a read of the entry
// at the lower bound. Full-table insert: no table access, status 3. The
// table port takes one read or one write per cycle.
// A result holds on the output until taken; no new item is accepted
// meanwhile. Reset empties the table (count to zero); an entry that was
// never written is never used in a result.
module sorted_table_first_match_search_top #(
  parameter int TABLE_DEPTH = stfms_pkg::TableDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic opcode,
  input  logic signed [31:0] value,
  input  logic last_query,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [10:0] position
);
  stfms_pkg::stfms_cmd_t cmd;
  stfms_pkg::stfms_sts_t sts;
  logic full_drop;
  logic [1:0] dp_status;
  logic [10:0] dp_position;

  stfms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .full_drop(full_drop),
    .cmd(cmd), .sts(sts)
  );

  stfms_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_opcode(opcode), .in_value(value), .in_last(last_query),
    .res_status(dp_status), .res_position(dp_position)
  );

  assign status = full_drop ? stfms_pkg::ST_FULL : dp_status;
  assign position = full_drop ? 11'd0 : dp_position;
endmodule

// File: sim/tb_sorted_table_first_match_search_top.sv
`timescale 1ns / 1ps
module tb_sorted_table_first_match_search_top;
  localparam int StallLimit = 10000;
  localparam int LongHold = 400;

  typedef struct packed {
    logic [1:0]  st;
    logic [10:0] pos;
  } answer_t;

  class match_scoreboard;
    logic signed [31:0] entries_q[$];
    answer_t answers_q[$];
    int errors;

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Insert goes after equal entries; query finds the first equal entry.
    function void note_item(logic op, logic signed [31:0] v, logic last);
      answer_t a;
      int idx;
      a.pos = '0;
      idx = 0;
      if (op == stfms_pkg::OP_INSERT) begin
        if (entries_q.size() >= stfms_pkg::TableDepth) begin
          a.st = stfms_pkg::ST_FULL;
        end else begin
          while (idx < entries_q.size() && entries_q[idx] <= v) idx++;
          entries_q.insert(idx, v);
          a.st = stfms_pkg::ST_INSERTED;
        end
      end else begin
        while (idx < entries_q.size() && entries_q[idx] < v) idx++;
        if (idx < entries_q.size() && entries_q[idx] == v) begin
          a.st = stfms_pkg::ST_FOUND;
          a.pos = 11'(idx + 1);
        end else begin
          a.st = stfms_pkg::ST_NOT_FOUND;
        end
        if (last) entries_q.delete();
      end
      answers_q.push_back(a);
    endfunction

    task check_answer(logic [1:0] st, logic [10:0] pos);
      answer_t a;
      if (answers_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d position %0d", st, pos));
      end else begin
        a = answers_q.pop_front();
        if (st !== a.st)
          report_mismatch($sformatf("status %0d, want %0d", st, a.st));
        if (pos !== a.pos)
          report_mismatch($sformatf("position %0d, want %0d", pos, a.pos));
      end
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_ready, opcode, last_query;
  logic signed [31:0] value;
  logic out_valid, out_ready;
  logic [1:0] status;
  logic [10:0] position;

  match_scoreboard sb;
  bit quiet;
  int items_sent, results_seen, idle_cycles;

  sorted_table_first_match_search_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .value(value), .last_query(last_query),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .position(position)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task send_item(logic op, logic signed [31:0] v, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    last_query <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, v, last);
    items_sent++;
  endtask

  // Inserts, then queries mostly of stored values, closed by a last query.
  task run_case(int n_ins, bit wide);
    logic signed [31:0] stored[$];
    logic signed [31:0] v;
    int n_q;
    for (int i = 0; i < n_ins; i++) begin
      v = wide ? $urandom : $urandom_range(0, 31) - 16;
      stored.push_back(v);
      send_item(stfms_pkg::OP_INSERT, v, $urandom_range(0, 5) == 0);
    end
    n_q = $urandom_range(1, 12);
    for (int i = 0; i <= n_q; i++) begin
      if (stored.size() != 0 && $urandom_range(0, 2) != 0)
        v = stored[$urandom_range(0, stored.size() - 1)];
      else
        v = wide ? $urandom : $urandom_range(0, 31) - 16;
      send_item(stfms_pkg::OP_QUERY, v, i == n_q);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the input.
  initial begin
    bit held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 60) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_answer(status, position);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    quiet = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = stfms_pkg::OP_INSERT;
    value = '0;
    last_query = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, duplicates, ignored last flag, clear
    send_item(stfms_pkg::OP_QUERY, 32'sd5, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sh8000_0000, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sh7fff_ffff, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sd0, 1'b0);
    send_item(stfms_pkg::OP_INSERT, -32'sd1, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sd5, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sd5, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sd5, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sd3, 1'b1);
    send_item(stfms_pkg::OP_QUERY, 32'sd5, 1'b0);
    send_item(stfms_pkg::OP_QUERY, 32'sh8000_0000, 1'b0);
    send_item(stfms_pkg::OP_QUERY, 32'sh7fff_ffff, 1'b0);
    send_item(stfms_pkg::OP_QUERY, 32'sd4, 1'b0);
    send_item(stfms_pkg::OP_QUERY, -32'sd1, 1'b0);
    send_item(stfms_pkg::OP_QUERY, 32'sd7, 1'b1);
    send_item(stfms_pkg::OP_QUERY, 32'sd5, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sd9, 1'b0);
    send_item(stfms_pkg::OP_INSERT, 32'sd9, 1'b0);
    send_item(stfms_pkg::OP_QUERY, 32'sd9, 1'b1);

    for (int c = 0; c < 4; c++) run_case($urandom_range(0, 30), c[0]);

    // fill the table in ascending order, then overflow it
    for (int i = 0; i < stfms_pkg::TableDepth; i++)
      send_item(stfms_pkg::OP_INSERT, {i[9:0], 22'd0} ^ 32'h8000_0000, 1'b0);
    for (int i = 0; i < 3; i++)
      send_item(stfms_pkg::OP_INSERT, $urandom, 1'($urandom_range(0, 1)));
    send_item(stfms_pkg::OP_QUERY, 32'sh8000_0000, 1'b0);
    send_item(stfms_pkg::OP_QUERY, 32'sh7fc0_0000, 1'b0);
    send_item(stfms_pkg::OP_QUERY, 32'sd1, 1'b1);

    while (items_sent < 1150) run_case($urandom_range(0, 40), 1'($urandom_range(0, 1)));
    quiet = 1;
    while (items_sent < 1250) run_case($urandom_range(0, 20), 1'($urandom_range(0, 1)));

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.answers_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
